// ----- src/oldq_pkg.sv -----
// Shared types for the ordered list engine: operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package oldq_pkg;

  localparam int IN_BITS  = 80;  // tdata width of the input channel
  localparam int OUT_BITS = 80;  // tdata width of the result channel
  localparam int FIELD_BITS = 32;  // width of value and place fields on the ports

  typedef enum logic [2:0] {
    OP_APPEND       = 3'd0,
    OP_PREPEND      = 3'd1,
    OP_SEARCH_VALUE = 3'd2,
    OP_SEARCH_PAIR  = 3'd3,
    OP_PEEK         = 3'd4,
    OP_POP          = 3'd5,
    OP_DELETE       = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS_CHK,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PEEK_RD,
    S_PEEK_WT,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    RP_ZERO,
    RP_LEN,
    RP_PEEK,
    RP_HIT
  } rp_sel_t;

  typedef struct packed {
    logic    capture;
    logic    issue;
    logic    dir_down;
    logic    rp_load;
    rp_sel_t rp_sel;
    logic    wr_shift;
    logic    wr_new;
    logic    len_inc;
    logic    len_dec;
    logic    res_load;
    logic    out_load;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic in_chk;
    logic pos_ok;
    op_t  cur_op;
    logic cur_chk;
    logic match;
    logic qv;
    logic more_up;
    logic more_dn;
    logic full;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- src/oldq_ctrl.sv -----
// Controller state machine for the ordered list engine.
// Depends on oldq_pkg; drives the datapath only through dp_cmd_t.
module oldq_ctrl
  import oldq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t  state, state_next;
  status_t code, code_next;

  // state and pending status code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_OK;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          cmd.rp_load = 1'b1;
          cmd.rp_sel  = RP_ZERO;
          code_next   = ST_OK;
          case (stat.in_op)
            OP_APPEND, OP_PREPEND: begin
              state_next = stat.in_chk ? S_SCAN : S_INS_CHK;
            end
            OP_SEARCH_VALUE, OP_SEARCH_PAIR, OP_DELETE: begin
              state_next = S_SCAN;
            end
            OP_PEEK, OP_POP: begin
              cmd.rp_sel = RP_PEEK;
              if (stat.pos_ok) begin
                state_next = S_PEEK_RD;
              end else begin
                code_next  = ST_BADIDX;
                state_next = S_FIN;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        if (stat.match) begin
          case (stat.cur_op)
            OP_APPEND, OP_PREPEND: begin
              code_next  = ST_DUP;
              state_next = S_FIN;
            end
            OP_DELETE: begin
              cmd.rp_load = 1'b1;
              cmd.rp_sel  = RP_HIT;
              state_next  = S_SHIFT_DN;
            end
            default: state_next = S_FIN;
          endcase
        end else if (!stat.qv && !stat.more_up) begin
          case (stat.cur_op)
            OP_APPEND, OP_PREPEND: state_next = S_INS_CHK;
            default: begin
              code_next  = ST_NOTFOUND;
              state_next = S_FIN;
            end
          endcase
        end else begin
          cmd.issue = 1'b1;
        end
      end
      S_INS_CHK: begin
        if (stat.full) begin
          code_next  = ST_FULL;
          state_next = S_FIN;
        end else if (stat.cur_op == OP_APPEND) begin
          cmd.wr_new  = 1'b1;
          cmd.len_inc = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.rp_load = 1'b1;
          cmd.rp_sel  = RP_LEN;
          state_next  = S_SHIFT_UP;
        end
      end
      // move entries one place toward the bottom, walking upward
      S_SHIFT_UP: begin
        cmd.dir_down = 1'b1;
        if (!stat.qv && !stat.more_dn) begin
          cmd.wr_new  = 1'b1;
          cmd.len_inc = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.issue    = 1'b1;
          cmd.wr_shift = 1'b1;
        end
      end
      // close the gap left by a removed entry
      S_SHIFT_DN: begin
        if (!stat.qv && !stat.more_up) begin
          cmd.len_dec = 1'b1;
          state_next  = S_FIN;
        end else begin
          cmd.issue    = 1'b1;
          cmd.wr_shift = 1'b1;
        end
      end
      S_PEEK_RD: begin
        cmd.issue  = 1'b1;
        state_next = S_PEEK_WT;
      end
      S_PEEK_WT: begin
        cmd.res_load = 1'b1;
        if (stat.cur_op == OP_POP) begin
          cmd.rp_load = 1'b1;
          cmd.rp_sel  = RP_HIT;
          state_next  = S_SHIFT_DN;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- src/oldq_dp.sv -----
// Datapath of the ordered list engine: entry memory, walk pointer, compare
// stage, list length and the result register. Depends on oldq_pkg.
module oldq_dp
  import oldq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [IN_BITS-1:0]  s_tdata,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_BITS-1:0] m_tdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int PW = ((LW > 7) ? LW : 7) + 2;

  // entry storage
  logic [VALUE_BITS-1:0] mem_v [DEPTH];
  logic [FIELD_BITS-1:0] mem_p [DEPTH];
  logic [VALUE_BITS-1:0] rd_v;
  logic [FIELD_BITS-1:0] rd_p;

  logic [LW-1:0]         len;
  logic [LW-1:0]         rp;
  logic [AW-1:0]         qi;
  logic                  qv;
  op_t                   cur_op;
  logic                  cur_chk;
  logic                  use_place;
  logic [VALUE_BITS-1:0] item_v;
  logic [FIELD_BITS-1:0] item_p;
  logic [FIELD_BITS-1:0] res_v;
  logic [FIELD_BITS-1:0] res_p;
  logic                  out_valid;
  logic [OUT_BITS-1:0]   out_data;

  // input fields
  op_t                   in_op;
  logic [FIELD_BITS-1:0] in_val;
  logic [FIELD_BITS-1:0] in_place;
  logic                  in_chk;
  logic                  in_mplace;
  logic [6:0]            in_pos;
  logic [95:0]           in_ext;
  logic [VALUE_BITS-1:0] in_sv;

  assign in_op     = op_t'(s_tdata[2:0]);
  assign in_val    = s_tdata[34:3];
  assign in_place  = s_tdata[66:35];
  assign in_chk    = s_tdata[67];
  assign in_mplace = s_tdata[68];
  assign in_pos    = s_tdata[75:69];
  assign in_ext    = {{64{in_val[FIELD_BITS-1]}}, in_val};
  assign in_sv     = in_ext[VALUE_BITS-1:0];

  // peek/pop index from the signed position
  logic signed [PW-1:0] pos_s;
  logic signed [PW-1:0] len_s;
  logic signed [PW-1:0] pos_sum;
  logic                 pos_ok;
  logic [AW-1:0]        pos_idx;

  assign pos_s   = PW'(signed'(in_pos));
  assign len_s   = signed'(PW'(len));
  assign pos_sum = len_s + pos_s;
  assign pos_ok  = in_pos[6] ? (pos_sum >= 0) : (pos_s < len_s);
  assign pos_idx = in_pos[6] ? AW'(pos_sum) : AW'(pos_s);

  // walk pointer and read address
  logic          issue_go;
  logic [AW-1:0] rd_addr;
  logic          more_up;
  logic          more_dn;

  assign more_up  = rp < len;
  assign more_dn  = rp != '0;
  assign issue_go = cmd.issue && (cmd.dir_down ? more_dn : more_up);
  assign rd_addr  = cmd.dir_down ? AW'(rp - LW'(1)) : AW'(rp);

  always_ff @(posedge clk) begin
    if (cmd.rp_load) begin
      case (cmd.rp_sel)
        RP_ZERO: rp <= '0;
        RP_LEN:  rp <= len;
        RP_PEEK: rp <= LW'(pos_idx);
        RP_HIT:  rp <= LW'(qi) + LW'(1);
        default: rp <= '0;
      endcase
    end else if (issue_go) begin
      rp <= cmd.dir_down ? rp - LW'(1) : rp + LW'(1);
    end
    qi <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
    end else begin
      qv <= issue_go;
    end
  end

  // memory read and write
  logic [AW-1:0] wr_addr;
  always_comb begin
    if (cmd.wr_shift) begin
      wr_addr = cmd.dir_down ? qi + AW'(1) : qi - AW'(1);
    end else begin
      wr_addr = (cur_op == OP_PREPEND) ? '0 : AW'(len);
    end
  end

  always_ff @(posedge clk) begin
    rd_v <= mem_v[rd_addr];
    rd_p <= mem_p[rd_addr];
    if (cmd.wr_shift && qv) begin
      mem_v[wr_addr] <= rd_v;
      mem_p[wr_addr] <= rd_p;
    end else if (cmd.wr_new) begin
      mem_v[wr_addr] <= item_v;
      mem_p[wr_addr] <= item_p;
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_op    <= in_op;
      cur_chk   <= in_chk;
      use_place <= (in_op == OP_SEARCH_PAIR) ||
                   (((in_op == OP_APPEND) || (in_op == OP_PREPEND)) && in_mplace);
      item_v    <= in_sv;
      item_p    <= in_place;
    end
  end

  // list length
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.len_inc) begin
      len <= len + LW'(1);
    end else if (cmd.len_dec) begin
      len <= len - LW'(1);
    end
  end

  // peeked entry, sign-extended from the stored width
  logic [VALUE_BITS+63:0] rd_ext;
  assign rd_ext = {{64{rd_v[VALUE_BITS-1]}}, rd_v};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_v <= '0;
      res_p <= '0;
    end else if (cmd.res_load) begin
      res_v <= rd_ext[FIELD_BITS-1:0];
      res_p <= rd_p;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {6'b0, 7'(len), res_p, res_v, cmd.code};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // status to the controller
  assign stat.in_op    = in_op;
  assign stat.in_chk   = in_chk;
  assign stat.pos_ok   = pos_ok;
  assign stat.cur_op   = cur_op;
  assign stat.cur_chk  = cur_chk;
  assign stat.match    = qv && (rd_v == item_v) && (!use_place || (rd_p == item_p));
  assign stat.qv       = qv;
  assign stat.more_up  = more_up;
  assign stat.more_dn  = more_dn;
  assign stat.full     = len == LW'(DEPTH);
  assign stat.out_free = !out_valid || m_tready;

endmodule

// ----- src/ordered_list_deque_engine.sv -----
// Ordered list engine: a list of up to DEPTH (value, place) entries with
// append, prepend, search, peek, pop and delete, one result item per input item.
//
// Input channel s_*: one operation item per handshake. Result channel m_*:
// one status item per operation, held in an output register until taken.
// An item is accepted only while the engine is idle; the result of the
// previous item may still be waiting on m_* at that time.
// An append without duplicate check writes the new entry directly and a
// peek reads one entry; a search or duplicate check walks the list at one
// entry per cycle, and a prepend, pop or delete shifts the entries behind
// the insert or removal point at one entry per cycle through the entry
// memory. The slowest item is a checked prepend into a list of DEPTH - 1
// entries, which walks the whole list and then shifts every entry.
// The memory walk dominates; the next item is taken once the result is
// registered and the output register is free.
// Reset empties the list (length zero) and clears the result valid flag;
// the entry memory is not cleared since only entries below the length
// are ever read. A stalled receiver holds the result and the engine then
// waits with the finished result before returning to idle.
// Depends on oldq_pkg, oldq_ctrl, oldq_dp.
module ordered_list_deque_engine
  import oldq_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // operation[2:0], item_value[34:3], item_place[66:35], check_duplicate[67],
  // match_place[68], position[75:69], zero[79:76]
  input  logic [IN_BITS-1:0]  s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // status[2:0], result_value[34:3], result_place[66:35], entry_count[73:67],
  // zero[79:74]
  output logic [OUT_BITS-1:0] m_tdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  oldq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oldq_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ----- sim/tb_top.sv -----
// Testbench for ordered_list_deque_engine: a directed table, then random operations,
// each result checked against a behavioral model of the list. Depends on oldq_pkg and ordered_list_deque_engine.
`timescale 1ns / 100ps

module tb_top;
  import oldq_pkg::*;

  localparam int LIST_DEPTH = 64;
  localparam int WATCH_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_BITS-1:0] m_tdata;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [31:0] place;
    logic [6:0]  count;
  } list_result_t;

  ordered_list_deque_engine DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #2 clk = ~clk;

  // Model state of the list
  logic [31:0] mdl_vals [LIST_DEPTH];
  logic [31:0] mdl_places [LIST_DEPTH];
  int mdl_len = 0;

  list_result_t pending_results[$];
  int fail_count = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int ops_seen [8];

  function automatic logic [IN_BITS-1:0] pack_op(logic [2:0] op, logic [31:0] v,
      logic [31:0] p, logic chk, logic mp, logic [6:0] pos);
    pack_op = '0;
    pack_op[2:0] = op;
    pack_op[34:3] = v;
    pack_op[66:35] = p;
    pack_op[67] = chk;
    pack_op[68] = mp;
    pack_op[75:69] = pos;
  endfunction

  function automatic int find_first(logic [31:0] v, logic [31:0] p, bit use_p);
    find_first = -1;
    for (int i = 0; i < mdl_len; i++)
      if (find_first < 0 && mdl_vals[i] == v && (!use_p || mdl_places[i] == p))
        find_first = i;
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < mdl_len; i++) begin
      mdl_vals[i] = mdl_vals[i + 1];
      mdl_places[i] = mdl_places[i + 1];
    end
    mdl_len--;
  endfunction

  // Predict one result and update the model list
  function automatic list_result_t apply_list_op(logic [IN_BITS-1:0] d);
    list_result_t r;
    logic [2:0] op;
    logic [31:0] v, p;
    int pos, idx;
    op = d[2:0];
    v = d[34:3];
    p = d[66:35];
    pos = $signed(d[75:69]);
    r = '0;
    r.status = ST_OK;
    idx = -1;
    case (op)
      OP_APPEND, OP_PREPEND: begin
        if (d[67] && find_first(v, p, d[68]) >= 0) r.status = ST_DUP;
        else if (mdl_len >= LIST_DEPTH) r.status = ST_FULL;
        else if (op == OP_APPEND) begin
          mdl_vals[mdl_len] = v;
          mdl_places[mdl_len] = p;
          mdl_len++;
        end else begin
          for (int i = mdl_len; i > 0; i--) begin
            mdl_vals[i] = mdl_vals[i - 1];
            mdl_places[i] = mdl_places[i - 1];
          end
          mdl_vals[0] = v;
          mdl_places[0] = p;
          mdl_len++;
        end
      end
      OP_SEARCH_VALUE, OP_SEARCH_PAIR:
        if (find_first(v, p, op == OP_SEARCH_PAIR) < 0) r.status = ST_NOTFOUND;
      OP_PEEK, OP_POP: begin
        if (pos >= 0 && pos < mdl_len) idx = pos;
        else if (pos < 0 && -pos <= mdl_len) idx = mdl_len + pos;
        else r.status = ST_BADIDX;
        if (idx >= 0) begin
          r.value = mdl_vals[idx];
          r.place = mdl_places[idx];
          if (op == OP_POP) drop_entry(idx);
        end
      end
      OP_DELETE: begin
        idx = find_first(v, '0, 1'b0);
        if (idx >= 0) drop_entry(idx);
        else r.status = ST_NOTFOUND;
      end
      default: ;
    endcase
    r.count = mdl_len[6:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  // Send one item: predict at the accepting edge, wait for handshake.
  // tvalid stays high into the next item when there is no gap.
  task automatic send_item(logic [IN_BITS-1:0] d, bit has_fixed, list_result_t fixed);
    list_result_t exp_r;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata <= d;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    exp_r = apply_list_op(d);
    ops_seen[d[2:0]]++;
    if (has_fixed && exp_r != fixed) begin
      $error("table row disagrees with model: row %h model %h", fixed, exp_r);
      fail_count++;
    end
    pending_results.push_back(has_fixed ? fixed : exp_r);
    @(negedge clk);
  endtask

  // Receiver: random stalls, compare each accepted result
  initial begin
    int gap;
    list_result_t got, want;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got.status = m_tdata[2:0];
      got.value = m_tdata[34:3];
      got.place = m_tdata[66:35];
      got.count = m_tdata[73:67];
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no expectation: %h", got);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.value != want.value) begin
          $error("result_value expected %h actual %h", want.value, got.value);
          fail_count++;
        end
        if (got.place != want.place) begin
          $error("result_place expected %h actual %h", want.place, got.place);
          fail_count++;
        end
        if (got.count != want.count) begin
          $error("entry_count expected %0d actual %0d", want.count, got.count);
          fail_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 5) ;
    endcase
  endfunction

  function automatic list_result_t row_result(logic [2:0] st, logic [31:0] v,
      logic [31:0] p, int cnt);
    list_result_t r;
    r.status = st;
    r.value = v;
    r.place = p;
    r.count = cnt[6:0];
    return r;
  endfunction

  typedef struct {
    logic [IN_BITS-1:0] d;
    bit fixed;
    list_result_t r;
  } table_row_t;

  initial begin
    table_row_t rows[$];
    list_result_t none;
    logic [2:0] op;
    logic [31:0] v, p;
    logic [6:0] pos;
    int k, mode;
    none = '0;

    // Directed table: empty list, extremes, duplicates, bad index, not found
    rows.push_back('{pack_op(OP_PEEK, 0, 0, 0, 0, 7'd0), 1, row_result(ST_BADIDX, 0, 0, 0)});
    rows.push_back('{pack_op(OP_POP, 0, 0, 0, 0, 7'h7F), 1, row_result(ST_BADIDX, 0, 0, 0)});
    rows.push_back('{pack_op(OP_DELETE, 5, 0, 0, 0, 0), 1, row_result(ST_NOTFOUND, 0, 0, 0)});
    rows.push_back('{pack_op(OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0), 1,
                     row_result(ST_OK, 0, 0, 1)});
    rows.push_back('{pack_op(OP_PREPEND, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0), 1,
                     row_result(ST_OK, 0, 0, 2)});
    rows.push_back('{pack_op(OP_APPEND, 32'h7FFF_FFFF, 1, 1, 0, 0), 1,
                     row_result(ST_DUP, 0, 0, 2)});
    rows.push_back('{pack_op(OP_APPEND, 32'h7FFF_FFFF, 1, 1, 1, 0), 0, none});
    rows.push_back('{pack_op(OP_PREPEND, 32'h7FFF_FFFF, 1, 1, 1, 0), 1,
                     row_result(ST_DUP, 0, 0, 3)});
    rows.push_back('{pack_op(OP_PEEK, 0, 0, 0, 0, 7'h7F), 1,
                     row_result(ST_OK, 32'h7FFF_FFFF, 1, 3)});
    rows.push_back('{pack_op(OP_PEEK, 0, 0, 0, 0, 7'h7D), 0, none});
    rows.push_back('{pack_op(OP_PEEK, 0, 0, 0, 0, 7'h7C), 1, row_result(ST_BADIDX, 0, 0, 3)});
    rows.push_back('{pack_op(OP_PEEK, 0, 0, 0, 0, 7'd3), 1, row_result(ST_BADIDX, 0, 0, 3)});
    rows.push_back('{pack_op(OP_SEARCH_VALUE, 32'h8000_0000, 0, 0, 0, 0), 1,
                     row_result(ST_OK, 0, 0, 3)});
    rows.push_back('{pack_op(OP_SEARCH_PAIR, 32'h8000_0000, 0, 0, 0, 0), 1,
                     row_result(ST_NOTFOUND, 0, 0, 3)});
    rows.push_back('{pack_op(OP_SEARCH_PAIR, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0), 0, none});
    rows.push_back('{pack_op(OP_POP, 0, 0, 0, 0, 7'd0), 0, none});
    rows.push_back('{pack_op(OP_DELETE, 32'h7FFF_FFFF, 0, 0, 0, 0), 0, none});
    rows.push_back('{pack_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 7'h7F), 1,
                     row_result(ST_OK, 0, 0, 1)});
    rows.push_back('{pack_op(OP_POP, 0, 0, 0, 0, 7'h40), 1, row_result(ST_BADIDX, 0, 0, 1)});
    rows.push_back('{pack_op(OP_POP, 0, 0, 0, 0, 7'h3F), 1, row_result(ST_BADIDX, 0, 0, 1)});
    rows.push_back('{pack_op(OP_POP, 0, 0, 0, 0, 7'h7F), 1,
                     row_result(ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 0)});

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_item(rows[i].d, rows[i].fixed, rows[i].r);

    // Fill to full so the full status and the deepest positions are reached
    for (int i = 0; i < LIST_DEPTH + 2; i++)
      send_item(pack_op(OP_APPEND, $urandom, $urandom, 0, 0, 0), 0, none);
    send_item(pack_op(OP_PEEK, 0, 0, 0, 0, 7'h40), 0, none);
    send_item(pack_op(OP_PEEK, 0, 0, 0, 0, 7'd63), 0, none);

    // Hold off until every result is in
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    // Random part: small value pool so searches and duplicates hit
    for (int n = 0; n < 1000; n++) begin
      mode = $urandom_range(0, 99);
      if (mode < 35) op = 3'($urandom_range(0, 1));
      else op = 3'($urandom_range(0, 7));
      // drain the list now and then
      if (mdl_len > 40 && op <= 1 && $urandom_range(0, 1)) op = OP_POP;
      if ($urandom_range(0, 9) < 7) begin
        v = $urandom_range(0, 7) - 3;
        p = $urandom_range(0, 3);
      end else begin
        v = ($urandom_range(0, 1)) ? $urandom : rand_word();
        p = ($urandom_range(0, 1)) ? $urandom : rand_word();
      end
      k = $urandom_range(0, 9);
      if (k < 7 && mdl_len > 0) begin
        pos = 7'($urandom_range(0, mdl_len - 1));
        if ($urandom_range(0, 1)) pos = 7'(-($urandom_range(1, mdl_len)));
      end else pos = 7'($urandom);
      send_item(pack_op(op, v, p, 1'($urandom), 1'($urandom), pos), 0, none);
    end
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (2 * LIST_DEPTH + 20) @(negedge clk);
    $display("Covered %0d results: appends %0d prepends %0d searches %0d peeks %0d",
             results_seen, ops_seen[0], ops_seen[1], ops_seen[2] + ops_seen[3], ops_seen[4]);
    $display("pops %0d deletes %0d unused code %0d, with full, empty and bad index cases",
             ops_seen[5], ops_seen[6], ops_seen[7]);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
